[sv/rwp_pkg.sv]
// Shared types, constants and color wheel function for the rainbow pattern block.
package rwp_pkg;

  localparam int unsigned PHASE_W    = 9;
  localparam logic [8:0]  PHASE_WRAP = 9'd256;
  localparam logic [3:0]  DIV_MSB    = 4'd8;   // 256 has nine dividend bits, MSB first
  localparam logic [7:0]  WHEEL_SEG1 = 8'd85;
  localparam logic [7:0]  WHEEL_SEG2 = 8'd170;
  localparam logic [7:0]  CHAN_MAX   = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Three-segment color wheel.
  function automatic rgb_t wheel_color(input logic [7:0] w);
    rgb_t       c;
    logic [7:0] p;
    logic [9:0] prod;
    logic [7:0] p3;
    if (w < WHEEL_SEG1) begin
      p = w;
    end else if (w < WHEEL_SEG2) begin
      p = w - WHEEL_SEG1;
    end else begin
      p = w - WHEEL_SEG2;
    end
    prod = {2'b00, p} + {1'b0, p, 1'b0};
    p3   = prod[7:0];
    if (w < WHEEL_SEG1) begin
      c.red   = p3;
      c.green = CHAN_MAX - p3;
      c.blue  = 8'd0;
    end else if (w < WHEEL_SEG2) begin
      c.red   = CHAN_MAX - p3;
      c.green = 8'd0;
      c.blue  = p3;
    end else begin
      c.red   = 8'd0;
      c.green = p3;
      c.blue  = CHAN_MAX - p3;
    end
    return c;
  endfunction

endpackage

[sv/rainbow_wheel_pattern.sv]
// Rainbow frame generator: phase tracking, hue spacing sequencer and color output stage.
//
// Each accepted beat with a nonzero step advances the rainbow phase and then produces
// FRAME_PIXELS color beats, one per position, the final one flagged by last_pixel. A zero
// step clears the phase and produces nothing. A frame first forms 256/ring_size, then
// emits one color per cycle while the output side does not stall. All of it runs through
// one 9-bit compare-subtract unit: nine restoring steps for the division, then one
// remainder carry per pixel to step the hue offset. Input is stalled from acceptance until
// the last color is loaded into the output register; ring_size (0 acts as 1) may only be
// written while idle.
module rainbow_wheel_pattern #(
  parameter int unsigned FRAME_PIXELS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] step_amount,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] pixel_index,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       last_pixel
);

  localparam int unsigned PW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam logic [PW-1:0] PIX_LAST = PW'(FRAME_PIXELS - 1);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t                        state;
  logic [7:0]                    ring_size;
  logic [rwp_pkg::PHASE_W-1:0]   rainbow_phase;
  logic [3:0]                    bit_idx;
  logic [7:0]                    q256;     // 256 / d, low 8 bits
  logic [7:0]                    rem256;   // 256 % d
  logic [7:0]                    q;        // running i*256/d, mod 256
  logic [7:0]                    r;        // running remainder / division workspace
  logic [PW-1:0]                 pix;

  logic [7:0]       div_eff;
  logic [8:0]       alu_a;
  logic             alu_ge;
  logic [8:0]       alu_diff;
  logic [7:0]       alu_out;
  logic             in_accept;
  logic             emit_go;
  logic [7:0]       hue;
  rwp_pkg::rgb_t    color;
  logic [PW+3:0]    pix_ext;

  assign div_eff   = (ring_size == 8'd0) ? 8'd1 : ring_size;
  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_go   = (state == EMIT) && (!out_valid || !out_stall);

  // Shared compare-subtract: division step while dividing, remainder carry while emitting.
  always_comb begin
    if (state == DIVIDE) begin
      alu_a = {r, (bit_idx == rwp_pkg::DIV_MSB)};
    end else begin
      alu_a = {1'b0, r} + {1'b0, rem256};
    end
    alu_ge   = (alu_a >= {1'b0, div_eff});
    alu_diff = alu_a - {1'b0, div_eff};
    alu_out  = alu_ge ? alu_diff[7:0] : alu_a[7:0];
  end

  assign hue     = q + rainbow_phase[7:0];
  assign color   = rwp_pkg::wheel_color(hue);
  assign pix_ext = {4'b0000, pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      ring_size     <= 8'd11;
      rainbow_phase <= '0;
      out_valid     <= 1'b0;
      bit_idx       <= '0;
      pix           <= '0;
    end else begin
      if (cfg_write_en) begin
        ring_size <= cfg_write_data;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_accept) begin
            if (step_amount == 8'd0) begin
              rainbow_phase <= '0;
            end else begin
              if (rainbow_phase < rwp_pkg::PHASE_WRAP) begin
                rainbow_phase <= rainbow_phase + {1'b0, step_amount};
              end else begin
                rainbow_phase <= '0;
              end
              bit_idx <= rwp_pkg::DIV_MSB;
              r       <= 8'd0;
              q256    <= 8'd0;
              state   <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          q256 <= {q256[6:0], alu_ge};
          if (bit_idx == 4'd0) begin
            rem256 <= alu_out;
            r      <= 8'd0;
            q      <= 8'd0;
            pix    <= '0;
            state  <= EMIT;
          end else begin
            r       <= alu_out;
            bit_idx <= bit_idx - 4'd1;
          end
        end
        EMIT: begin
          if (emit_go) begin
            pixel_index <= pix_ext[3:0];
            red         <= color.red;
            green       <= color.green;
            blue        <= color.blue;
            last_pixel  <= (pix == PIX_LAST);
            r           <= alu_out;
            q           <= q + q256 + {7'd0, alu_ge};
            if (pix == PIX_LAST) begin
              state <= IDLE;
            end else begin
              pix <= pix + PW'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_nonzero_starts_divide: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (step_amount != 8'd0) |=> state == DIVIDE)
    else $error("nonzero step did not start the division");

  a_last_flag_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> pixel_index == 4'(FRAME_PIXELS - 1))
    else $error("last_pixel on wrong position");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    rainbow_phase <= 9'd510)
    else $error("rainbow phase out of range");

  a_emit_holds_output: assert property (@(posedge clk) disable iff (rst)
    state == EMIT && out_valid && out_stall |=> $stable(pix))
    else $error("pixel sequencer advanced under output stall");

endmodule
